[rtl/mpd_pkg.sv]
// ----------------------------------------------------------------------------
// Motor position PD package
// Shared constants for the position controller and its divider.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int unsigned NumPositionsDefault = 5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;

  localparam logic [CfgIdxW-1:0] CfgPropGain      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDerivGain     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxVoltage    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTargetSpeed   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgVoltageSlew   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStepPeriod    = 3'd5;

  localparam logic [15:0] PropGainReset     = 16'd384;
  localparam logic [15:0] DerivGainReset    = 16'd1966;
  localparam logic [14:0] MaxVoltageReset   = 15'd3277;
  localparam logic [15:0] TargetSpeedReset  = 16'd16384;
  localparam logic [17:0] VoltageSlewReset  = 18'd16384;
  localparam logic [15:0] StepPeriodReset   = 16'd1000;

  localparam logic [31:0] DtMaxMs   = 32'd100;
  localparam logic [9:0]  MsPerS    = 10'd1000;
  localparam logic [16:0] TwoPiQ14  = 17'd102944;

  localparam int unsigned DivNumW = 34;
  localparam int unsigned DivDenW = 10;

endpackage

[rtl/mpd_div.sv]
// ----------------------------------------------------------------------------
// Motor position PD divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpd_div #(
  parameter int unsigned NumW = mpd_pkg::DivNumW,
  parameter int unsigned DenW = mpd_pkg::DivDenW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic            ge;

  always_comb begin
    trial  = {rem_q, num_q[NumW-1]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], ge};
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[rtl/motor_position_pd_with_slew.sv]
// ----------------------------------------------------------------------------
// Motor position PD controller with slew limiting
// Steps a goal through evenly spaced angles and drives Uq by PD control.
// ----------------------------------------------------------------------------
// The slave stream takes one word per control tick: the shaft angle and a
// millisecond timestamp. The master stream gives one word per tick: the
// clamped and slew-limited Uq in Q12 volts, the shaft angle for commutation
// and the current target position index. Gains and limits are written
// through the configuration channel, which is always ready.
// A word is worked through, from acceptance to a valid result, by three
// passes through the shared one-bit-per-cycle divider (34 iterations each,
// then the quotient is handed over) plus the steps of the shared
// multiplier and the sequencer. The block holds one word at a time: the
// slave side is not ready from acceptance until the cycle after the
// result has been taken, so no new word is taken before the last one is
// through. While the receiver stalls, the result holds and no new word is
// accepted.
// After reset the registers hold their default gains and limits, and the
// first word seeds the goal and smoothed target from its own shaft angle.
// ----------------------------------------------------------------------------
module motor_position_pd_with_slew #(
  parameter int unsigned NumPositions = mpd_pkg::NumPositionsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // shaft_angle [15:0], time_ms [47:16]
  input  logic [47:0]                  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // drive_voltage [15:0], commutation_angle [31:16], position_index [34:32]
  output logic [39:0]                  m_axis_tdata_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mpd_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(NumPositions);
  localparam int unsigned NumW = mpd_pkg::DivNumW;
  localparam int unsigned DenW = mpd_pkg::DivDenW;

  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StPrep   = 5'd1;
  localparam logic [4:0] StMulTs  = 5'd2;
  localparam logic [4:0] StDivTs  = 5'd3;
  localparam logic [4:0] StWaitTs = 5'd4;
  localparam logic [4:0] StSmooth = 5'd5;
  localparam logic [4:0] StDivVs  = 5'd6;
  localparam logic [4:0] StWaitVs = 5'd7;
  localparam logic [4:0] StMulPe  = 5'd8;
  localparam logic [4:0] StMulPed = 5'd9;
  localparam logic [4:0] StMulDd  = 5'd10;
  localparam logic [4:0] StMulDk  = 5'd11;
  localparam logic [4:0] StSum    = 5'd12;
  localparam logic [4:0] StMulLo  = 5'd13;
  localparam logic [4:0] StMulHi  = 5'd14;
  localparam logic [4:0] StDivUq  = 5'd15;
  localparam logic [4:0] StWaitUq = 5'd16;
  localparam logic [4:0] StOut    = 5'd17;

  logic [15:0] pos_tab [NumPositions];
  for (genvar k = 0; k < NumPositions; k++) begin : g_pos
    assign pos_tab[k] = 16'((k * 65536 + NumPositions / 2) / NumPositions);
  end

  logic [4:0]  state_q, state_d;
  logic [15:0] prop_q, deriv_q, tsc_q, period_q;
  logic [14:0] vmax_q;
  logic [17:0] vsc_q;

  logic            started_q;
  logic [31:0]     prev_tick_q, change_tick_q, now_q;
  logic [IdxW-1:0] idx_q;
  logic [15:0]     goal_q, smooth_q, prev_angle_q, prev_v_q, angle_q;
  logic [6:0]      dt_q;
  logic [16:0]     step_q, vstep_q;
  logic [56:0]     prod_q, prod_d;
  logic            sign_e_q, sign_d_q, ssign_q;
  logic [46:0]     pterm_q, smag_q;
  logic [40:0]     acc_q;

  logic [39:0] mul_a;
  logic [16:0] mul_b;

  logic            div_start, div_done;
  logic [NumW-1:0] div_num, div_quot;
  logic [DenW-1:0] div_den;

  logic [31:0]     el, chg_b, since;
  logic [6:0]      dt_new;
  logic            adv;
  logic [IdxW-1:0] idx_n;
  logic [15:0]     goal_b, terr, e_val, d_val, e_mag, d_mag;
  logic [17:0]     terr18, step18;
  logic [48:0]     pv, dv, s49;
  logic [64:0]     m_val;
  logic [14:0]     qc;
  logic [19:0]     uq20, last20, hi20, lo20, res20;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q   <= mpd_pkg::PropGainReset;
      deriv_q  <= mpd_pkg::DerivGainReset;
      vmax_q   <= mpd_pkg::MaxVoltageReset;
      tsc_q    <= mpd_pkg::TargetSpeedReset;
      vsc_q    <= mpd_pkg::VoltageSlewReset;
      period_q <= mpd_pkg::StepPeriodReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mpd_pkg::CfgPropGain:    prop_q   <= cfg_data_i[15:0];
        mpd_pkg::CfgDerivGain:   deriv_q  <= cfg_data_i[15:0];
        mpd_pkg::CfgMaxVoltage:  vmax_q   <= cfg_data_i[14:0];
        mpd_pkg::CfgTargetSpeed: tsc_q    <= cfg_data_i[15:0];
        mpd_pkg::CfgVoltageSlew: vsc_q    <= cfg_data_i;
        mpd_pkg::CfgStepPeriod:  period_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    el     = now_q - prev_tick_q;
    dt_new = (started_q && el != '0 && el <= mpd_pkg::DtMaxMs) ? el[6:0] : 7'd1;
    chg_b  = started_q ? change_tick_q : now_q;
    goal_b = started_q ? goal_q : angle_q;
    since  = now_q - chg_b;
    adv    = since >= {16'd0, period_q};
    idx_n  = idx_q;
    if (adv) begin
      idx_n = (idx_q == IdxW'(NumPositions - 1)) ? '0 : idx_q + IdxW'(1);
    end
    terr   = goal_q - smooth_q;
    terr18 = {{2{terr[15]}}, terr};
    step18 = {1'b0, step_q};
    e_val  = smooth_q - angle_q;
    d_val  = angle_q - prev_angle_q;
    e_mag  = e_val[15] ? 16'(-e_val) : e_val;
    d_mag  = d_val[15] ? 16'(-d_val) : d_val;
    pv     = sign_e_q ? 49'(-{2'b0, pterm_q}) : {2'b0, pterm_q};
    dv     = sign_d_q ? 49'(-{7'b0, prod_q[41:0]}) : {7'b0, prod_q[41:0]};
    s49    = pv - dv;
    m_val  = {24'd0, acc_q} + {1'b0, prod_q[39:0], 24'd0};
    qc     = (div_quot > NumW'(vmax_q)) ? vmax_q : div_quot[14:0];
    uq20   = ssign_q ? 20'(-{5'b0, qc}) : {5'b0, qc};
    last20 = {{4{prev_v_q[15]}}, prev_v_q};
    hi20   = last20 + {3'b0, vstep_q};
    lo20   = last20 - {3'b0, vstep_q};
    if ($signed(uq20) > $signed(hi20)) begin
      res20 = hi20;
    end else if ($signed(uq20) < $signed(lo20)) begin
      res20 = lo20;
    end else begin
      res20 = uq20;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StMulTs: begin
        mul_a = 40'(tsc_q);
        mul_b = 17'(dt_q);
      end
      StSmooth: begin
        mul_a = 40'(vsc_q);
        mul_b = 17'(dt_q);
      end
      StMulPe: begin
        mul_a = 40'(prop_q);
        mul_b = 17'(e_mag);
      end
      StMulPed: begin
        mul_a = 40'(prod_q[31:0]);
        mul_b = 17'(dt_q);
      end
      StMulDd: begin
        mul_a = 40'(deriv_q);
        mul_b = 17'(d_mag);
      end
      StMulDk: begin
        mul_a = 40'(prod_q[31:0]);
        mul_b = 17'(mpd_pkg::MsPerS);
      end
      StMulLo: begin
        mul_a = 40'(smag_q[23:0]);
        mul_b = mpd_pkg::TwoPiQ14;
      end
      StMulHi: begin
        mul_a = 40'(smag_q[46:24]);
        mul_b = mpd_pkg::TwoPiQ14;
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DenW'(mpd_pkg::MsPerS);
    unique case (state_q)
      StDivTs, StDivVs: begin
        div_start = 1'b1;
        div_num   = {9'd0, prod_q[24:0]} + NumW'(mpd_pkg::MsPerS / 2);
      end
      StDivUq: begin
        div_start = 1'b1;
        div_num   = NumW'(m_val[64:33]) + NumW'(dt_q);
        div_den   = {2'b0, dt_q, 1'b0};
      end
      default: ;
    endcase
  end

  mpd_div #(
    .NumW(NumW),
    .DenW(DenW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (s_axis_tvalid_i) state_d = StPrep;
      StPrep:   state_d = StMulTs;
      StMulTs:  state_d = StDivTs;
      StDivTs:  state_d = StWaitTs;
      StWaitTs: if (div_done) state_d = StSmooth;
      StSmooth: state_d = StDivVs;
      StDivVs:  state_d = StWaitVs;
      StWaitVs: if (div_done) state_d = StMulPe;
      StMulPe:  state_d = StMulPed;
      StMulPed: state_d = StMulDd;
      StMulDd:  state_d = StMulDk;
      StMulDk:  state_d = StSum;
      StSum:    state_d = StMulLo;
      StMulLo:  state_d = StMulHi;
      StMulHi:  state_d = StDivUq;
      StDivUq:  state_d = StWaitUq;
      StWaitUq: if (div_done) state_d = StOut;
      StOut:    if (m_axis_tready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      started_q     <= 1'b0;
      prev_tick_q   <= '0;
      change_tick_q <= '0;
      idx_q         <= '0;
      goal_q        <= '0;
      smooth_q      <= '0;
      prev_angle_q  <= '0;
      prev_v_q      <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StPrep: begin
          started_q     <= 1'b1;
          prev_tick_q   <= now_q;
          idx_q         <= idx_n;
          goal_q        <= adv ? pos_tab[idx_n] : goal_b;
          change_tick_q <= adv ? now_q : chg_b;
          if (!started_q) begin
            smooth_q     <= angle_q;
            prev_angle_q <= angle_q;
            prev_v_q     <= '0;
          end
        end
        StSmooth: begin
          if ($signed(terr18) > $signed(step18)) begin
            smooth_q <= smooth_q + step_q[15:0];
          end else if ($signed(terr18) < -$signed(step18)) begin
            smooth_q <= smooth_q - step_q[15:0];
          end else begin
            smooth_q <= goal_q;
          end
        end
        StMulDd:  prev_angle_q <= angle_q;
        StWaitUq: if (div_done) prev_v_q <= res20[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == StIdle && s_axis_tvalid_i) begin
      angle_q <= s_axis_tdata_i[15:0];
      now_q   <= s_axis_tdata_i[47:16];
    end
    if (state_q == StPrep) begin
      dt_q <= dt_new;
    end
    if (state_q == StWaitTs && div_done) begin
      step_q <= div_quot[16:0];
    end
    if (state_q == StWaitVs && div_done) begin
      vstep_q <= div_quot[16:0];
    end
    if (state_q == StMulPe) begin
      sign_e_q <= e_val[15];
    end
    if (state_q == StMulDd) begin
      sign_d_q <= d_val[15];
      pterm_q  <= {prod_q[38:0], 8'd0};
    end
    if (state_q == StSum) begin
      ssign_q <= s49[48];
      smag_q  <= s49[48] ? 47'(-s49) : s49[46:0];
    end
    if (state_q == StMulHi) begin
      acc_q <= prod_q[40:0];
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = {5'd0, 3'(idx_q), angle_q, prev_v_q};

  // The block never takes a word while a result is still on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  // Exactly one result leaves per accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) |=> !m_axis_tvalid_o)
    else $error("result repeated");

  // The position index stays inside the ring of positions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(idx_q) < NumPositions))
    else $error("position index out of range");

  // A divider result only arrives in a state that waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StWaitTs || state_q == StWaitVs || state_q == StWaitUq))
    else $error("divider finished outside a wait state");

endmodule
